FILE: sv/ptc_pkg.sv
package ptc_pkg;

  localparam int PosW = 24;
  localparam int VelW = 16;
  localparam int RadW = 16;
  localparam int LvlW = 3;
  localparam int CfgIdxW = 2;

  // grade codes
  localparam logic [LvlW-1:0] LVL_NONE     = 3'd0;
  localparam logic [LvlW-1:0] LVL_CAUTION  = 3'd1;
  localparam logic [LvlW-1:0] LVL_WARNING  = 3'd2;
  localparam logic [LvlW-1:0] LVL_CRITICAL = 3'd3;
  localparam logic [LvlW-1:0] LVL_PANIC    = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PANIC    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CRITICAL = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WARNING  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_CAUTION  = 2'd3;

  localparam logic [RadW-1:0] PANIC_RST    = 16'd128;
  localparam logic [RadW-1:0] CRITICAL_RST = 16'd256;
  localparam logic [RadW-1:0] WARNING_RST  = 16'd512;
  localparam logic [RadW-1:0] CAUTION_RST  = 16'd1024;

  // pipeline depth of the front part and depth of the middle queue
  localparam int FrontStages = 4;
  localparam int FrontCntW   = 3;
  localparam int QDepth      = 8;
  localparam int QAddrW      = 3;
  localparam int QCntW       = 4;

  typedef struct packed {
    logic            last;
    logic            flying;
    logic [LvlW-1:0] level;
  } grade_item_t;

endpackage

FILE: sv/ptc_front.sv
module ptc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ptc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ptc_pkg::RadW-1:0]     cfg_data,
  input  logic                         in_valid,
  input  logic [ptc_pkg::PosW-1:0]     own_x,
  input  logic [ptc_pkg::PosW-1:0]     own_y,
  input  logic [ptc_pkg::VelW-1:0]     own_vx,
  input  logic [ptc_pkg::VelW-1:0]     own_vy,
  input  logic [ptc_pkg::PosW-1:0]     peer_x,
  input  logic [ptc_pkg::PosW-1:0]     peer_y,
  input  logic [ptc_pkg::VelW-1:0]     peer_vx,
  input  logic [ptc_pkg::VelW-1:0]     peer_vy,
  input  logic                         flying,
  input  logic                         peer_present,
  input  logic                         last_peer,
  output logic                         out_valid,
  output ptc_pkg::grade_item_t         out_item,
  output logic [ptc_pkg::FrontCntW-1:0] inflight
);
  import ptc_pkg::*;

  typedef struct packed {
    logic last;
    logic flying;
    logic graded;
  } tag_t;

  // radii and their squares
  logic [RadW-1:0] panic_r, critical_r, warning_r, caution_r;
  logic [2*RadW-1:0] panic_r2, critical_r2, warning_r2, caution_r2;

  // valid bits and tags per stage
  logic [FrontStages-1:0] vld;
  tag_t tag1, tag2, tag3, tag4;

  // stage 1: differences
  logic signed [PosW:0] dx, dy;
  logic signed [VelW:0] dvx, dvy;
  // stage 2: products
  logic [2*PosW:0] dxx, dyy;
  logic signed [PosW+VelW+1:0] pxv, pyv;
  logic signed [2*PosW:0] dxx_full, dyy_full;
  // stage 3: distance squared and closing numerator
  logic [2*PosW+1:0] d2;
  logic signed [PosW+VelW+3:0] n;
  logic signed [PosW+VelW+3:0] n_next;
  // stage 4
  logic [2*32-1:0]   nsq;
  logic [33:0]       d2_lo;
  logic [LvlW-1:0]   rad_lvl, rad_lvl_next;
  logic              near, npos, nbig, ttc_ok;
  logic              closing;

  always_ff @(posedge clk) begin
    if (rst) begin
      panic_r    <= PANIC_RST;
      critical_r <= CRITICAL_RST;
      warning_r  <= WARNING_RST;
      caution_r  <= CAUTION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PANIC:    panic_r    <= cfg_data;
        REG_CRITICAL: critical_r <= cfg_data;
        REG_WARNING:  warning_r  <= cfg_data;
        REG_CAUTION:  caution_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // squares follow the radii in the next cycle; an item needs longer to reach them
  always_ff @(posedge clk) begin
    panic_r2    <= panic_r * panic_r;
    critical_r2 <= critical_r * critical_r;
    warning_r2  <= warning_r * warning_r;
    caution_r2  <= caution_r * caution_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FrontStages-2:0], in_valid};
    end
  end

  assign dxx_full = dx * dx;
  assign dyy_full = dy * dy;
  assign n_next   = -({{2{pxv[PosW+VelW+1]}}, pxv} + {{2{pyv[PosW+VelW+1]}}, pyv});

  always_comb begin
    if (d2 < {18'd0, panic_r2}) begin
      rad_lvl_next = LVL_PANIC;
    end else if (d2 < {18'd0, critical_r2}) begin
      rad_lvl_next = LVL_CRITICAL;
    end else if (d2 < {18'd0, warning_r2}) begin
      rad_lvl_next = LVL_WARNING;
    end else if (d2 < {18'd0, caution_r2}) begin
      rad_lvl_next = LVL_CAUTION;
    end else begin
      rad_lvl_next = LVL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1
    dx   <= {peer_x[PosW-1], peer_x} - {own_x[PosW-1], own_x};
    dy   <= {peer_y[PosW-1], peer_y} - {own_y[PosW-1], own_y};
    dvx  <= {peer_vx[VelW-1], peer_vx} - {own_vx[VelW-1], own_vx};
    dvy  <= {peer_vy[VelW-1], peer_vy} - {own_vy[VelW-1], own_vy};
    tag1 <= '{last: last_peer, flying: flying, graded: flying & peer_present};
    // stage 2
    dxx  <= dxx_full[2*PosW:0];
    dyy  <= dyy_full[2*PosW:0];
    pxv  <= dx * dvx;
    pyv  <= dy * dvy;
    tag2 <= tag1;
    // stage 3
    d2   <= {1'b0, dxx} + {1'b0, dyy};
    n    <= n_next;
    tag3 <= tag2;
    // stage 4
    nsq     <= n[31:0] * n[31:0];
    d2_lo   <= d2[33:0];
    rad_lvl <= rad_lvl_next;
    near    <= d2 < {16'd0, warning_r2, 2'b00};
    npos    <= !n[PosW+VelW+3] && (n != '0);
    nbig    <= n[PosW+VelW+2:32] != '0;
    ttc_ok  <= d2 < {6'd0, n[PosW+VelW+2:0], 1'b0};
    tag4    <= tag3;
  end

  // near bounds d2 below 2^34, so the shifted compare fits 48 bits
  assign closing = nbig || (nsq > {16'd0, d2_lo, 14'd0});

  always_comb begin
    out_item.last   = tag4.last;
    out_item.flying = tag4.flying;
    if (!tag4.graded) begin
      out_item.level = LVL_NONE;
    end else if (npos && near && closing && ttc_ok && (rad_lvl < LVL_WARNING)) begin
      out_item.level = LVL_WARNING;
    end else begin
      out_item.level = rad_lvl;
    end
  end

  assign out_valid = vld[FrontStages-1];
  assign inflight  = FrontCntW'($countones(vld));

endmodule

FILE: sv/ptc_queue.sv
module ptc_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  ptc_pkg::grade_item_t        push_item,
  input  logic                        pop,
  output logic                        empty,
  output ptc_pkg::grade_item_t        head,
  output logic [ptc_pkg::QCntW-1:0]   count
);
  import ptc_pkg::*;

  grade_item_t       entries [QDepth];
  logic [QAddrW-1:0] wptr, rptr;
  logic              do_pop;

  assign empty  = (count == '0);
  assign head   = entries[rptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/ptc_back.sv
module ptc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  ptc_pkg::grade_item_t       q_head,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [ptc_pkg::LvlW-1:0]   threat_level
);
  import ptc_pkg::*;

  logic [LvlW-1:0] worst;
  logic [LvlW-1:0] worst_next;
  logic            res_valid;

  // a last beat needs the result register free (or freed this cycle)
  assign q_pop      = !q_empty && (!q_head.last || !res_valid || pop);
  assign worst_next = (q_head.level > worst) ? q_head.level : worst;
  assign empty      = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      worst     <= LVL_NONE;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      if (q_pop) begin
        if (q_head.last) begin
          res_valid    <= 1'b1;
          threat_level <= q_head.flying ? worst_next : LVL_NONE;
          worst        <= LVL_NONE;
        end else begin
          worst <= worst_next;
        end
      end
    end
  end

endmodule

FILE: sv/proximity_threat_classifier_core.sv
// Proximity threat classifier. Push one neighbour beat per cycle; the front
// grades it in a four-stage pipeline (differences, products, sums, radius and
// closing-speed compares) and drops the grade into an eight-entry queue, from
// which the back folds it into the running worst grade at one beat per cycle.
// Sustained rate is one item per clock unless a last beat meets an unpopped
// result. The last_peer beat yields one threat_level result, held until
// popped. full rises when pipeline plus queued items reach eight, so it
// shows only while the result side stalls on a pending result. Radius
// writes pass the radius and square registers; write them only while idle.
module proximity_threat_classifier_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ptc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ptc_pkg::RadW-1:0]     cfg_data,
  input  logic                         push,
  output logic                         full,
  input  logic [ptc_pkg::PosW-1:0]     own_x,
  input  logic [ptc_pkg::PosW-1:0]     own_y,
  input  logic [ptc_pkg::VelW-1:0]     own_vx,
  input  logic [ptc_pkg::VelW-1:0]     own_vy,
  input  logic [ptc_pkg::PosW-1:0]     peer_x,
  input  logic [ptc_pkg::PosW-1:0]     peer_y,
  input  logic [ptc_pkg::VelW-1:0]     peer_vx,
  input  logic [ptc_pkg::VelW-1:0]     peer_vy,
  input  logic                         flying,
  input  logic                         peer_present,
  input  logic                         last_peer,
  output logic                         empty,
  input  logic                         pop,
  output logic [ptc_pkg::LvlW-1:0]     threat_level
);
  import ptc_pkg::*;

  logic                  accept;
  logic                  f_valid;
  grade_item_t           f_item;
  logic [FrontCntW-1:0]  inflight;
  logic                  q_empty;
  logic                  q_pop;
  grade_item_t           q_head;
  logic [QCntW-1:0]      q_count;

  // credit check: every beat in the pipeline must find a queue slot
  assign full   = ({1'b0, inflight} + q_count) >= QCntW'(QDepth);
  assign accept = push && !full;

  ptc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (accept),
    .own_x        (own_x),
    .own_y        (own_y),
    .own_vx       (own_vx),
    .own_vy       (own_vy),
    .peer_x       (peer_x),
    .peer_y       (peer_y),
    .peer_vx      (peer_vx),
    .peer_vy      (peer_vy),
    .flying       (flying),
    .peer_present (peer_present),
    .last_peer    (last_peer),
    .out_valid    (f_valid),
    .out_item     (f_item),
    .inflight     (inflight)
  );

  ptc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head),
    .count     (q_count)
  );

  ptc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .threat_level (threat_level)
  );

endmodule

FILE: sv/ptc_checker.sv
module ptc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [ptc_pkg::LvlW-1:0]     threat_level
);
  import ptc_pkg::*;

  // a waiting result holds until popped
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(threat_level)))
    else $error("result changed or vanished while stalled");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (threat_level <= LVL_PANIC))
    else $error("threat_level out of range");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("not clean after reset");

  // occupancy only grows on an accepted beat
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted beat");

endmodule

bind proximity_threat_classifier_core ptc_checker u_ptc_checker (
  .clk          (clk),
  .rst          (rst),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .threat_level (threat_level)
);
